// ===== hw/rtl/per_channel_std_deviation_assert.svh =====
// Assertion helpers used by the RTL of the deviation block.
`ifndef PER_CHANNEL_STD_DEVIATION_ASSERT_SVH
`define PER_CHANNEL_STD_DEVIATION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/psd_pkg.sv =====
package psd_pkg;

	localparam int CH_W         = 3;
	localparam int SAMPLE_W     = 17;
	localparam int CFG_W        = 4;
	localparam int RESULT_LIMIT = 8;
	localparam logic [SAMPLE_W-1:0] SAMPLE_ONE = 17'd65536;

	localparam logic OP_ACCUM  = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef struct packed {
		logic                operation;
		logic [CH_W-1:0]     channel;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0]     channel_out;
		logic [SAMPLE_W-1:0] deviation;
		logic                empty_res;
		logic                last;
	} out_item_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_LOAD,
		BS_MULA,
		BS_MULB,
		BS_SQRT,
		BS_DIV,
		BS_EMIT
	} back_state_t;

endpackage

// ===== hw/rtl/per_channel_std_deviation.sv =====
// Per-channel population standard deviation of Q1.16 samples.
// Input channel (in_valid/in_stall/in_data): operation 0 adds a sample to
// its channel, operation 1 reports every channel in use and clears all sums.
// Samples for channels beyond the configured count are dropped, samples
// above 1.0 are clamped, and a full count ignores further samples.
// Output channel (out_valid/out_stall/out_data): one result per channel in
// order, with last set on the final one; an empty channel reports zero.
// cfg_we/cfg_data set the channel count (0 acts as 1); write it while idle.
// Samples are taken one per cycle while no report runs, through a two-entry
// queue; each costs one read-modify-write of its channel's registers.
// A report steps each nonzero channel through LOAD, the bit-serial multiply
// (MULA, MULB), square root (SQRT) and divide (DIV), then EMIT; an empty
// channel goes from LOAD straight to EMIT. The first result is presented
// once the first channel leaves EMIT after the finish transfer.
// A stalled receiver holds the result register, the sequencer waits and the
// queue fills, then in_stall rises. Reset clears all sums and sets the
// channel count to 4; no clearing pass is needed.
module per_channel_std_deviation #(
	parameter int MAX_CHANNELS = 8,
	parameter int COUNT_BITS   = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [psd_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  psd_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output psd_pkg::out_item_t        out_data
);
	import psd_pkg::*;

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	in_item_t         q_wdata;
	in_item_t         q_rdata;
	logic [CFG_W-1:0] eff;

	// Front: configuration and item classification.
	psd_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.q_full(q_full), .q_push(q_push), .q_data(q_wdata), .eff(eff)
	);

	// Queue between front and back.
	psd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_wdata),
		.full(q_full), .pop(q_pop), .valid(q_valid), .pop_data(q_rdata)
	);

	// Back: accumulators and deviation sequencer.
	psd_back #(.MAX_CHANNELS(MAX_CHANNELS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .eff(eff), .q_valid(q_valid),
		.q_data(q_rdata), .q_pop(q_pop), .out_valid(out_valid),
		.out_stall(out_stall), .out_data(out_data)
	);

endmodule

// ===== hw/rtl/psd_front.sv =====
module psd_front #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [psd_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  psd_pkg::in_item_t           in_data,
	input  logic                        q_full,
	output logic                        q_push,
	output psd_pkg::in_item_t           q_data,
	output logic [psd_pkg::CFG_W-1:0]   eff
);
	import psd_pkg::*;

	localparam int NCH = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

	logic [CFG_W-1:0] cfg_q;

	// Channel count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(4);
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	// Zero acts as one, and the count is clamped to the channels that exist.
	always_comb begin
		if (cfg_q == '0) begin
			eff = CFG_W'(1);
		end else if (cfg_q > CFG_W'(NCH)) begin
			eff = CFG_W'(NCH);
		end else begin
			eff = cfg_q;
		end
	end

	// Classify: finish items always pass, samples only for channels in use.
	always_comb begin
		in_stall          = q_full;
		q_data.operation  = in_data.operation;
		q_data.channel    = in_data.channel;
		q_data.sample     = (in_data.sample > SAMPLE_ONE) ? SAMPLE_ONE : in_data.sample;
		q_push            = in_valid && !q_full &&
			((in_data.operation == OP_FINISH) || (CFG_W'(in_data.channel) < eff));
	end

endmodule

// ===== hw/rtl/psd_queue.sv =====
module psd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  psd_pkg::in_item_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output psd_pkg::in_item_t pop_data
);
	import psd_pkg::*;

	in_item_t   mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign valid    = (cnt_q != 2'd0);
	assign pop_data = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/psd_back.sv =====
module psd_back #(
	parameter int MAX_CHANNELS = 8,
	parameter int COUNT_BITS   = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [psd_pkg::CFG_W-1:0] eff,
	input  logic                      q_valid,
	input  psd_pkg::in_item_t         q_data,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output psd_pkg::out_item_t        out_data
);
	import psd_pkg::*;

	`include "per_channel_std_deviation_assert.svh"

	localparam int NCH = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;
	localparam int IW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int CB  = COUNT_BITS;
	localparam int SW  = COUNT_BITS + SAMPLE_W;
	localparam int QW  = COUNT_BITS + 2 * SAMPLE_W;
	localparam int PW  = CB + QW;
	localparam int RW  = PW / 2;
	localparam int STW = $clog2(SW + 1);

	// Per-channel accumulators.
	logic [CB-1:0] cnt_q [NCH];
	logic [SW-1:0] sum_q [NCH];
	logic [QW-1:0] sq_q  [NCH];

	back_state_t      state_q, state_d;
	logic [CH_W-1:0]  k_q;
	logic [CB-1:0]    n_q;
	logic [PW:0]      mcand_q;
	logic [SW-1:0]    mplier_q;
	logic [PW:0]      acc_q;
	logic [STW-1:0]   step_q;
	logic [PW-1:0]    dsrc_q;
	logic [RW+1:0]    rem_q;
	logic [RW-1:0]    root_q;
	logic [RW-1:0]    quo_q;
	logic [CB-1:0]    drem_q;
	logic [SAMPLE_W-1:0] dev_q;
	logic             empty_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [IW-1:0]       acc_idx;
	logic [IW-1:0]       rd_idx;
	logic [2*SAMPLE_W-1:0] smp_sq;
	logic                last_w;
	logic                load_out;
	logic                step_end;
	logic [PW:0]         acc_add;
	logic [PW:0]         acc_sub;
	logic [RW+3:0]       rem_ext;
	logic [RW+3:0]       trial;
	logic                sq_ge;
	logic [RW+3:0]       rem_sub;
	logic [RW-1:0]       root_nx;
	logic [CB:0]         drem_ext;
	logic                dv_ge;
	logic [CB:0]         drem_sub;
	logic [RW-1:0]       quo_nx;

	assign acc_idx  = q_data.channel[IW-1:0];
	assign rd_idx   = k_q[IW-1:0];
	assign smp_sq   = q_data.sample * q_data.sample;
	assign last_w   = (CFG_W'(k_q) + CFG_W'(1)) == eff;
	assign step_end = (step_q == STW'(1));

	// Shift-add multiply step.
	assign acc_add = acc_q + mcand_q;
	assign acc_sub = acc_q - mcand_q;

	// Square root step: two radicand bits per cycle.
	assign rem_ext = {rem_q, dsrc_q[PW-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign sq_ge   = rem_ext >= trial;
	assign rem_sub = rem_ext - trial;
	assign root_nx = {root_q[RW-2:0], sq_ge};

	// Restoring division step: one quotient bit per cycle.
	assign drem_ext = {drem_q, quo_q[RW-1]};
	assign dv_ge    = drem_ext >= {1'b0, n_q};
	assign drem_sub = drem_ext - {1'b0, n_q};
	assign quo_nx   = {quo_q[RW-2:0], dv_ge};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BS_IDLE: begin
				if (q_valid && q_data.operation == OP_FINISH) begin
					state_d = BS_LOAD;
				end
			end
			BS_LOAD: begin
				state_d = (cnt_q[rd_idx] == '0) ? BS_EMIT : BS_MULA;
			end
			BS_MULA: begin
				if (step_end) state_d = BS_MULB;
			end
			BS_MULB: begin
				if (step_end) state_d = BS_SQRT;
			end
			BS_SQRT: begin
				if (step_end) state_d = BS_DIV;
			end
			BS_DIV: begin
				if (step_end) state_d = BS_EMIT;
			end
			BS_EMIT: begin
				if (load_out) state_d = last_w ? BS_IDLE : BS_LOAD;
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// Handshake outputs of the sequencer.
	always_comb begin
		q_pop    = (state_q == BS_IDLE) && q_valid;
		load_out = (state_q == BS_EMIT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				k_q <= '0;
			end else if (load_out && !last_w) begin
				k_q <= k_q + CH_W'(1);
			end
		end
	end

	// Accumulator update on a sample, full clear after the last result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				cnt_q[i] <= '0;
				sum_q[i] <= '0;
				sq_q[i]  <= '0;
			end
		end else if (load_out && last_w) begin
			for (int i = 0; i < NCH; i++) begin
				cnt_q[i] <= '0;
				sum_q[i] <= '0;
				sq_q[i]  <= '0;
			end
		end else if (q_pop && q_data.operation == OP_ACCUM) begin
			if (cnt_q[acc_idx] != {CB{1'b1}}) begin
				cnt_q[acc_idx] <= cnt_q[acc_idx] + CB'(1);
				sum_q[acc_idx] <= sum_q[acc_idx] + SW'(q_data.sample);
				sq_q[acc_idx]  <= sq_q[acc_idx] + QW'(smp_sq);
			end
		end
	end

	// Deviation datapath: n*sumsq - sum^2, square root, divide by n.
	always_ff @(posedge clk) begin
		unique case (state_q)
			BS_LOAD: begin
				n_q      <= cnt_q[rd_idx];
				mcand_q  <= (PW+1)'(sq_q[rd_idx]);
				mplier_q <= SW'(cnt_q[rd_idx]);
				acc_q    <= '0;
				step_q   <= STW'(CB);
				dev_q    <= '0;
				empty_q  <= (cnt_q[rd_idx] == '0);
			end
			BS_MULA: begin
				if (mplier_q[0]) acc_q <= acc_add;
				if (step_end) begin
					mcand_q  <= (PW+1)'(sum_q[rd_idx]);
					mplier_q <= sum_q[rd_idx];
					step_q   <= STW'(SW);
				end else begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					step_q   <= step_q - STW'(1);
				end
			end
			BS_MULB: begin
				if (mplier_q[0]) acc_q <= acc_sub;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				if (step_end) begin
					// A negative difference only arises from rounding-free data as zero spread.
					if (mplier_q[0]) begin
						dsrc_q <= acc_sub[PW] ? '0 : acc_sub[PW-1:0];
					end else begin
						dsrc_q <= acc_q[PW] ? '0 : acc_q[PW-1:0];
					end
					rem_q  <= '0;
					root_q <= '0;
					step_q <= STW'(RW);
				end else begin
					step_q <= step_q - STW'(1);
				end
			end
			BS_SQRT: begin
				rem_q  <= sq_ge ? rem_sub[RW+1:0] : rem_ext[RW+1:0];
				root_q <= root_nx;
				dsrc_q <= dsrc_q << 2;
				if (step_end) begin
					quo_q  <= root_nx;
					drem_q <= '0;
					step_q <= STW'(RW);
				end else begin
					step_q <= step_q - STW'(1);
				end
			end
			BS_DIV: begin
				drem_q <= dv_ge ? drem_sub[CB-1:0] : drem_ext[CB-1:0];
				quo_q  <= quo_nx;
				step_q <= step_q - STW'(1);
				if (step_end) begin
					dev_q <= quo_nx[SAMPLE_W-1:0];
				end
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	// Output register: a finished result waits here for its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.channel_out <= k_q;
			out_q.deviation   <= dev_q;
			out_q.empty_res   <= empty_q;
			out_q.last        <= last_w;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PSD_ASSERT_IMPLY(a_no_pop_busy, clk, arst_n, state_q != BS_IDLE, !q_pop, "pop while busy")
	`PSD_ASSERT_IMPLY(a_k_range, clk, arst_n, state_q != BS_IDLE, CFG_W'(k_q) < eff, "k beyond count")
	`PSD_ASSERT_NEXT(a_clear_last, clk, arst_n, load_out && last_w, cnt_q[0] == '0, "no clear")
	`PSD_ASSERT_IMPLY(a_dev_range, clk, arst_n, out_valid_q, (out_q.deviation <= SAMPLE_ONE) && (!out_q.empty_res || out_q.deviation == '0), "bad deviation")

endmodule
